>>> rtl/assert_macros.svh
// Assertion helpers used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every rising edge while reset is not asserted.
`define ASSERT_ON(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("assertion lbl failed");

// Checked on every rising edge, reset included.
`define ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("assertion lbl failed");

`endif

>>> rtl/mbsl_pkg.sv
package mbsl_pkg;

  localparam int unsigned DEF_MAX_WIDTH  = 1024;
  localparam int unsigned DEF_MAX_HEIGHT = 1024;
  localparam int unsigned DEF_MAX_WIN_W  = 64;
  localparam int unsigned DEF_MAX_WIN_H  = 64;

  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned CFG_IW    = 11;
  localparam int unsigned CFG_WW    = 7;

  localparam int unsigned IMG_W_RST = 640;
  localparam int unsigned IMG_H_RST = 480;
  localparam int unsigned WIN_W_RST = 16;
  localparam int unsigned WIN_H_RST = 16;

  localparam int unsigned PIX_W  = 8;
  localparam int unsigned CS_W   = 14;
  localparam int unsigned SUM_W  = 20;
  localparam int unsigned OUT_XW = 10;
  localparam int unsigned OUT_YW = 10;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_IMG_W = 2'd0,
    CFG_IMG_H = 2'd1,
    CFG_WIN_W = 2'd2,
    CFG_WIN_H = 2'd3
  } cfg_idx_e;

  // Configuration, already clamped to the legal ranges.
  typedef struct packed {
    logic [CFG_IW-1:0] img_w;
    logic [CFG_IW-1:0] img_h;
    logic [CFG_WW-1:0] win_w;
    logic [CFG_WW-1:0] win_h;
  } cfg_t;

  // Position flags of one pixel, worked out when it is accepted.
  typedef struct packed {
    logic x_first;
    logic x_short;
    logic y_first;
    logic y_short;
    logic cand;
    logic last;
  } pos_flags_t;

  typedef struct packed {
    logic [OUT_XW-1:0] x;
    logic [OUT_YW-1:0] y;
    logic [SUM_W-1:0]  sum;
    logic              found;
  } res_t;

  function automatic int unsigned addr_w(int unsigned depth);
    return (depth > 1) ? $clog2(depth) : 1;
  endfunction

  function automatic logic [CFG_IW-1:0] clamp_img(logic [CFG_IW-1:0] v, int unsigned hi);
    logic [CFG_IW-1:0] r;
    r = v;
    if (v == '0) r = CFG_IW'(1);
    else if (32'(v) > hi) r = CFG_IW'(hi);
    return r;
  endfunction

  function automatic logic [CFG_WW-1:0] clamp_win(logic [CFG_WW-1:0] v, int unsigned hi);
    logic [CFG_WW-1:0] r;
    r = v;
    if (v == '0) r = CFG_WW'(1);
    else if (32'(v) > hi) r = CFG_WW'(hi);
    return r;
  endfunction

endpackage

>>> rtl/mbsl_cfg_regs.sv
module mbsl_cfg_regs
  import mbsl_pkg::*;
#(
  parameter int unsigned MAX_WIDTH  = DEF_MAX_WIDTH,
  parameter int unsigned MAX_HEIGHT = DEF_MAX_HEIGHT,
  parameter int unsigned MAX_WIN_W  = DEF_MAX_WIN_W,
  parameter int unsigned MAX_WIN_H  = DEF_MAX_WIN_H
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [CFG_IW-1:0]    cfg_wdata_i,
  output cfg_t                 cfg_o
);

  // Values are clamped as they are written, so users see legal sizes only.
  cfg_t cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.img_w <= clamp_img(CFG_IW'(IMG_W_RST), MAX_WIDTH);
      cfg_q.img_h <= clamp_img(CFG_IW'(IMG_H_RST), MAX_HEIGHT);
      cfg_q.win_w <= clamp_win(CFG_WW'(WIN_W_RST), MAX_WIN_W);
      cfg_q.win_h <= clamp_win(CFG_WW'(WIN_H_RST), MAX_WIN_H);
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CFG_IMG_W: cfg_q.img_w <= clamp_img(cfg_wdata_i, MAX_WIDTH);
        CFG_IMG_H: cfg_q.img_h <= clamp_img(cfg_wdata_i, MAX_HEIGHT);
        CFG_WIN_W: cfg_q.win_w <= clamp_win(cfg_wdata_i[CFG_WW-1:0], MAX_WIN_W);
        CFG_WIN_H: cfg_q.win_h <= clamp_win(cfg_wdata_i[CFG_WW-1:0], MAX_WIN_H);
        default: ;
      endcase
    end
  end

  assign cfg_o = cfg_q;

endmodule

>>> rtl/mbsl_scan.sv
module mbsl_scan
  import mbsl_pkg::*;
#(
  parameter int unsigned MAX_WIDTH  = DEF_MAX_WIDTH,
  parameter int unsigned MAX_HEIGHT = DEF_MAX_HEIGHT,
  parameter int unsigned MAX_WIN_H  = DEF_MAX_WIN_H,
  localparam int unsigned COL_W     = addr_w(MAX_WIDTH),
  localparam int unsigned ROW_W     = addr_w(MAX_HEIGHT),
  localparam int unsigned SLOT_W    = addr_w(MAX_WIN_H)
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              accept_i,
  input  cfg_t              cfg_i,
  output logic [COL_W-1:0]  x_o,
  output logic [ROW_W-1:0]  y_o,
  output logic [SLOT_W-1:0] slot_o,
  output logic [SLOT_W-1:0] old_slot_o,
  output logic [COL_W-1:0]  hist_addr_o,
  output pos_flags_t        flags_o
);

  logic [COL_W-1:0]  col_q;
  logic [ROW_W-1:0]  row_q;
  logic [SLOT_W-1:0] slot_q;
  logic              end_row;
  logic              end_frame;
  logic [31:0]       old_sum;
  logic [31:0]       old_wrap;

  assign end_row   = (32'(col_q) + 32'd1) >= 32'(cfg_i.img_w);
  assign end_frame = end_row && ((32'(row_q) + 32'd1) >= 32'(cfg_i.img_h));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q  <= '0;
      row_q  <= '0;
      slot_q <= '0;
    end else if (accept_i) begin
      if (end_row) begin
        col_q <= '0;
        if (end_frame) begin
          row_q  <= '0;
          slot_q <= '0;
        end else begin
          row_q  <= row_q + ROW_W'(1);
          slot_q <= (32'(slot_q) == MAX_WIN_H - 1) ? '0 : slot_q + SLOT_W'(1);
        end
      end else begin
        col_q <= col_q + COL_W'(1);
      end
    end
  end

  // Ring slot of the row that leaves the box, window height rows back.
  assign old_sum  = 32'(slot_q) + MAX_WIN_H - 32'(cfg_i.win_h);
  assign old_wrap = (old_sum >= MAX_WIN_H) ? old_sum - MAX_WIN_H : old_sum;

  assign x_o         = col_q;
  assign y_o         = row_q;
  assign slot_o      = slot_q;
  assign old_slot_o  = SLOT_W'(old_wrap);
  assign hist_addr_o = COL_W'(32'(col_q) - 32'(cfg_i.win_w));

  assign flags_o.x_first = (col_q == '0);
  assign flags_o.x_short = 32'(col_q) < 32'(cfg_i.win_w);
  assign flags_o.y_first = (row_q == '0);
  assign flags_o.y_short = 32'(row_q) < 32'(cfg_i.win_h);
  assign flags_o.cand    = !flags_o.x_short && !flags_o.y_short;
  assign flags_o.last    = end_frame;

endmodule

>>> rtl/mbsl_col_sum.sv
module mbsl_col_sum
  import mbsl_pkg::*;
#(
  parameter int unsigned MAX_WIDTH  = DEF_MAX_WIDTH,
  parameter int unsigned MAX_HEIGHT = DEF_MAX_HEIGHT,
  parameter int unsigned MAX_WIN_H  = DEF_MAX_WIN_H,
  localparam int unsigned COL_W     = addr_w(MAX_WIDTH),
  localparam int unsigned ROW_W     = addr_w(MAX_HEIGHT),
  localparam int unsigned SLOT_W    = addr_w(MAX_WIN_H),
  localparam int unsigned RS_AW     = SLOT_W + COL_W
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              accept_i,
  input  logic [PIX_W-1:0]  pixel_i,
  input  logic [COL_W-1:0]  x_i,
  input  logic [ROW_W-1:0]  y_i,
  input  logic [SLOT_W-1:0] slot_i,
  input  logic [SLOT_W-1:0] old_slot_i,
  input  logic [COL_W-1:0]  hist_addr_i,
  input  pos_flags_t        flags_i,
  output logic              clr_busy_o,
  output logic              a_pend_o,
  output logic              b_valid_o,
  output logic [CS_W-1:0]   b_cs_o,
  output logic [CS_W-1:0]   b_hist_o,
  output logic [COL_W-1:0]  b_x_o,
  output logic [ROW_W-1:0]  b_y_o,
  output pos_flags_t        b_flags_o
);

  logic [CS_W-1:0]  col_mem [2**COL_W];
  logic [PIX_W-1:0] rs_mem  [2**RS_AW];

  logic              clr_busy_q;
  logic [RS_AW-1:0]  clr_addr_q;

  logic              a_valid_q;
  logic [PIX_W-1:0]  a_pix_q;
  logic [COL_W-1:0]  a_x_q;
  logic [ROW_W-1:0]  a_y_q;
  logic [SLOT_W-1:0] a_slot_q;
  logic [SLOT_W-1:0] a_old_slot_q;
  logic [COL_W-1:0]  a_hist_addr_q;
  pos_flags_t        a_flags_q;
  logic [CS_W-1:0]   col_rd_q;
  logic [CS_W-1:0]   hist_rd_q;
  logic [PIX_W-1:0]  rs_rd_q;

  logic              fwd_valid_q;
  logic [COL_W-1:0]  fwd_x_q;
  logic [SLOT_W-1:0] fwd_slot_q;
  logic [CS_W-1:0]   fwd_cs_q;
  logic [PIX_W-1:0]  fwd_pix_q;

  logic              b_valid_q;
  logic [CS_W-1:0]   b_cs_q;
  logic [CS_W-1:0]   b_hist_q;
  logic [COL_W-1:0]  b_x_q;
  logic [ROW_W-1:0]  b_y_q;
  pos_flags_t        b_flags_q;

  logic              hit_col;
  logic              hit_hist;
  logic              hit_rs;
  logic [CS_W-1:0]   col_val;
  logic [CS_W-1:0]   hist_val;
  logic [PIX_W-1:0]  old_pix;
  logic [CS_W-1:0]   cs_d;

  logic              mem_we;
  logic [COL_W-1:0]  col_waddr;
  logic [CS_W-1:0]   col_wdata;
  logic [RS_AW-1:0]  rs_waddr;
  logic [PIX_W-1:0]  rs_wdata;

  // Both stores are swept to zero once after reset.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_busy_q <= 1'b1;
      clr_addr_q <= '0;
    end else if (clr_busy_q) begin
      clr_addr_q <= clr_addr_q + RS_AW'(1);
      if (clr_addr_q == '1) begin
        clr_busy_q <= 1'b0;
      end
    end
  end

  // A read that meets a write to the same entry on the same edge gets the old
  // data, so the value written on that edge is kept in the forwarding registers.
  assign hit_col  = fwd_valid_q && (fwd_x_q == a_x_q);
  assign hit_hist = fwd_valid_q && (fwd_x_q == a_hist_addr_q);
  assign hit_rs   = hit_col && (fwd_slot_q == a_old_slot_q);

  assign col_val  = hit_col  ? fwd_cs_q  : col_rd_q;
  assign hist_val = hit_hist ? fwd_cs_q  : hist_rd_q;
  assign old_pix  = hit_rs   ? fwd_pix_q : rs_rd_q;

  always_comb begin
    if (a_flags_q.y_first) begin
      cs_d = CS_W'(a_pix_q);
    end else if (a_flags_q.y_short) begin
      cs_d = col_val + CS_W'(a_pix_q);
    end else begin
      cs_d = col_val + CS_W'(a_pix_q) - CS_W'(old_pix);
    end
  end

  assign mem_we    = clr_busy_q || a_valid_q;
  assign col_waddr = clr_busy_q ? clr_addr_q[COL_W-1:0] : a_x_q;
  assign col_wdata = clr_busy_q ? '0 : cs_d;
  assign rs_waddr  = clr_busy_q ? clr_addr_q : {a_slot_q, a_x_q};
  assign rs_wdata  = clr_busy_q ? '0 : a_pix_q;

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      col_mem[col_waddr] <= col_wdata;
    end
    col_rd_q  <= col_mem[x_i];
    hist_rd_q <= col_mem[hist_addr_i];
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      rs_mem[rs_waddr] <= rs_wdata;
    end
    rs_rd_q <= rs_mem[{old_slot_i, x_i}];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q   <= 1'b0;
      fwd_valid_q <= 1'b0;
      b_valid_q   <= 1'b0;
    end else begin
      a_valid_q   <= accept_i;
      fwd_valid_q <= a_valid_q;
      b_valid_q   <= a_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept_i) begin
      a_pix_q       <= pixel_i;
      a_x_q         <= x_i;
      a_y_q         <= y_i;
      a_slot_q      <= slot_i;
      a_old_slot_q  <= old_slot_i;
      a_hist_addr_q <= hist_addr_i;
      a_flags_q     <= flags_i;
    end
    if (a_valid_q) begin
      fwd_x_q    <= a_x_q;
      fwd_slot_q <= a_slot_q;
      fwd_cs_q   <= cs_d;
      fwd_pix_q  <= a_pix_q;
      b_cs_q     <= cs_d;
      b_hist_q   <= hist_val;
      b_x_q      <= a_x_q;
      b_y_q      <= a_y_q;
      b_flags_q  <= a_flags_q;
    end
  end

  assign clr_busy_o = clr_busy_q;
  assign a_pend_o   = a_valid_q && a_flags_q.last;
  assign b_valid_o  = b_valid_q;
  assign b_cs_o     = b_cs_q;
  assign b_hist_o   = b_hist_q;
  assign b_x_o      = b_x_q;
  assign b_y_o      = b_y_q;
  assign b_flags_o  = b_flags_q;

endmodule

>>> rtl/mbsl_best_track.sv
module mbsl_best_track
  import mbsl_pkg::*;
#(
  parameter int unsigned MAX_WIDTH  = DEF_MAX_WIDTH,
  parameter int unsigned MAX_HEIGHT = DEF_MAX_HEIGHT,
  localparam int unsigned COL_W     = addr_w(MAX_WIDTH),
  localparam int unsigned ROW_W     = addr_w(MAX_HEIGHT)
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             b_valid_i,
  input  logic [CS_W-1:0]  b_cs_i,
  input  logic [CS_W-1:0]  b_hist_i,
  input  logic [COL_W-1:0] b_x_i,
  input  logic [ROW_W-1:0] b_y_i,
  input  pos_flags_t       b_flags_i,
  output logic [1:0]       res_pend_o,
  output logic             result_valid_o,
  input  logic             result_ready_i,
  output res_t             result_o
);

  logic              c_valid_q;
  logic [SUM_W-1:0]  c_sum_q;
  logic [COL_W-1:0]  c_x_q;
  logic [ROW_W-1:0]  c_y_q;
  logic              c_cand_q;
  logic              c_last_q;

  logic [SUM_W-1:0]  best_sum_q;
  logic [COL_W-1:0]  best_x_q;
  logic [ROW_W-1:0]  best_y_q;
  logic              found_q;

  res_t              out_q;
  logic              out_valid_q;
  res_t              skid_q;
  logic              skid_valid_q;

  logic [SUM_W-1:0]  sum_base;
  logic [SUM_W-1:0]  sum_drop;
  logic [SUM_W-1:0]  sum_d;
  logic              better;
  logic [SUM_W-1:0]  nb_sum;
  logic [COL_W-1:0]  nb_x;
  logic [ROW_W-1:0]  nb_y;
  logic              nb_found;
  logic              push;
  res_t              push_res;
  logic              pop;
  logic              out_free;

  // Box sum along the row: add the new column sum, drop the one that leaves.
  assign sum_base = b_flags_i.x_first ? '0 : c_sum_q;
  assign sum_drop = b_flags_i.x_short ? '0 : SUM_W'(b_hist_i);
  assign sum_d    = sum_base + SUM_W'(b_cs_i) - sum_drop;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      c_valid_q <= 1'b0;
    end else begin
      c_valid_q <= b_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (b_valid_i) begin
      c_sum_q  <= sum_d;
      c_x_q    <= b_x_i;
      c_y_q    <= b_y_i;
      c_cand_q <= b_flags_i.cand;
      c_last_q <= b_flags_i.last;
    end
  end

  // Strictly greater keeps the first box in raster order on a tie.
  assign better   = c_cand_q && (!found_q || (c_sum_q > best_sum_q));
  assign nb_sum   = better ? c_sum_q : best_sum_q;
  assign nb_x     = better ? c_x_q : best_x_q;
  assign nb_y     = better ? c_y_q : best_y_q;
  assign nb_found = found_q || better;

  assign push           = c_valid_q && c_last_q;
  assign push_res.x     = OUT_XW'(nb_x);
  assign push_res.y     = OUT_YW'(nb_y);
  assign push_res.sum   = nb_sum;
  assign push_res.found = nb_found;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      best_sum_q <= '0;
      best_x_q   <= '0;
      best_y_q   <= '0;
      found_q    <= 1'b0;
    end else if (c_valid_q) begin
      if (c_last_q) begin
        best_sum_q <= '0;
        best_x_q   <= '0;
        best_y_q   <= '0;
        found_q    <= 1'b0;
      end else begin
        best_sum_q <= nb_sum;
        best_x_q   <= nb_x;
        best_y_q   <= nb_y;
        found_q    <= nb_found;
      end
    end
  end

  // Two-entry result queue: output register plus a skid register.
  assign pop      = out_valid_q && result_ready_i;
  assign out_free = !out_valid_q || pop;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (out_free) begin
      if (skid_valid_q) begin
        out_valid_q  <= 1'b1;
        skid_valid_q <= push;
      end else begin
        out_valid_q  <= push;
      end
    end else if (push) begin
      skid_valid_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_free) begin
      if (skid_valid_q) begin
        out_q <= skid_q;
        if (push) begin
          skid_q <= push_res;
        end
      end else if (push) begin
        out_q <= push_res;
      end
    end else if (push) begin
      skid_q <= push_res;
    end
  end

  assign res_pend_o     = 2'(push) + 2'(out_valid_q) + 2'(skid_valid_q);
  assign result_valid_o = out_valid_q;
  assign result_o       = out_q;

endmodule

>>> rtl/max_box_sum_locator.sv
// Channel   Direction  Handshake                       Payload
// pixel     in         pixel_valid_i / pixel_ready_o   pixel_i
// result    out        result_valid_o / result_ready_i best_x_o, best_y_o, best_sum_o,
//                                                      window_found_o
// config    in         cfg_we_i                        cfg_idx_i, cfg_wdata_i
//
// One pixel is accepted per cycle while pixel_ready_o is high; the line store and
// column sum memories take one write and their reads on every cycle. A frame's
// result enters the result queue once its last pixel has passed the a, b and c
// registers. After reset both stores are swept to zero, one entry a cycle, over
// 2**(SLOT_W+COL_W) addresses (65536 with the default sizes); configuration writes are
// taken. pixel_ready_o is low then and while two frame results are waiting or in flight.
module max_box_sum_locator
  import mbsl_pkg::*;
#(
  parameter int unsigned MAX_WIDTH  = DEF_MAX_WIDTH,
  parameter int unsigned MAX_HEIGHT = DEF_MAX_HEIGHT,
  parameter int unsigned MAX_WIN_W  = DEF_MAX_WIN_W,
  parameter int unsigned MAX_WIN_H  = DEF_MAX_WIN_H
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [CFG_IW-1:0]    cfg_wdata_i,
  input  logic                 pixel_valid_i,
  output logic                 pixel_ready_o,
  input  logic [PIX_W-1:0]     pixel_i,
  output logic                 result_valid_o,
  input  logic                 result_ready_i,
  output logic [OUT_XW-1:0]    best_x_o,
  output logic [OUT_YW-1:0]    best_y_o,
  output logic [SUM_W-1:0]     best_sum_o,
  output logic                 window_found_o
);

  localparam int unsigned COL_W  = addr_w(MAX_WIDTH);
  localparam int unsigned ROW_W  = addr_w(MAX_HEIGHT);
  localparam int unsigned SLOT_W = addr_w(MAX_WIN_H);

  cfg_t              cfg;
  logic              accept;
  logic [COL_W-1:0]  scan_x;
  logic [ROW_W-1:0]  scan_y;
  logic [SLOT_W-1:0] scan_slot;
  logic [SLOT_W-1:0] scan_old_slot;
  logic [COL_W-1:0]  scan_hist_addr;
  pos_flags_t        scan_flags;

  logic              clr_busy;
  logic              a_pend;
  logic              b_valid;
  logic [CS_W-1:0]   b_cs;
  logic [CS_W-1:0]   b_hist;
  logic [COL_W-1:0]  b_x;
  logic [ROW_W-1:0]  b_y;
  pos_flags_t        b_flags;
  logic [1:0]        res_pend;
  logic [2:0]        pend_cnt;
  res_t              result;

  mbsl_cfg_regs #(
    .MAX_WIDTH (MAX_WIDTH),
    .MAX_HEIGHT(MAX_HEIGHT),
    .MAX_WIN_W (MAX_WIN_W),
    .MAX_WIN_H (MAX_WIN_H)
  ) u_cfg_regs (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_wdata_i(cfg_wdata_i),
    .cfg_o      (cfg)
  );

  mbsl_scan #(
    .MAX_WIDTH (MAX_WIDTH),
    .MAX_HEIGHT(MAX_HEIGHT),
    .MAX_WIN_H (MAX_WIN_H)
  ) u_scan (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .accept_i   (accept),
    .cfg_i      (cfg),
    .x_o        (scan_x),
    .y_o        (scan_y),
    .slot_o     (scan_slot),
    .old_slot_o (scan_old_slot),
    .hist_addr_o(scan_hist_addr),
    .flags_o    (scan_flags)
  );

  mbsl_col_sum #(
    .MAX_WIDTH (MAX_WIDTH),
    .MAX_HEIGHT(MAX_HEIGHT),
    .MAX_WIN_H (MAX_WIN_H)
  ) u_col_sum (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .accept_i   (accept),
    .pixel_i    (pixel_i),
    .x_i        (scan_x),
    .y_i        (scan_y),
    .slot_i     (scan_slot),
    .old_slot_i (scan_old_slot),
    .hist_addr_i(scan_hist_addr),
    .flags_i    (scan_flags),
    .clr_busy_o (clr_busy),
    .a_pend_o   (a_pend),
    .b_valid_o  (b_valid),
    .b_cs_o     (b_cs),
    .b_hist_o   (b_hist),
    .b_x_o      (b_x),
    .b_y_o      (b_y),
    .b_flags_o  (b_flags)
  );

  mbsl_best_track #(
    .MAX_WIDTH (MAX_WIDTH),
    .MAX_HEIGHT(MAX_HEIGHT)
  ) u_best_track (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .b_valid_i     (b_valid),
    .b_cs_i        (b_cs),
    .b_hist_i      (b_hist),
    .b_x_i         (b_x),
    .b_y_i         (b_y),
    .b_flags_i     (b_flags),
    .res_pend_o    (res_pend),
    .result_valid_o(result_valid_o),
    .result_ready_i(result_ready_i),
    .result_o      (result)
  );

  // Results that are queued or still in the pipeline must fit the two slots.
  assign pend_cnt = 3'(a_pend) + 3'(b_valid && b_flags.last) + 3'(res_pend);
  assign pixel_ready_o = !clr_busy && (pend_cnt < 3'd2);
  assign accept        = pixel_valid_i && pixel_ready_o;

  assign best_x_o       = result.x;
  assign best_y_o       = result.y;
  assign best_sum_o     = result.sum;
  assign window_found_o = result.found;

endmodule

>>> rtl/mbsl_checker.sv
`include "assert_macros.svh"

module mbsl_checker
  import mbsl_pkg::*;
(
  input logic              clk_i,
  input logic              rst_ni,
  input logic              pixel_ready_o,
  input logic              result_valid_o,
  input logic              result_ready_i,
  input logic [OUT_XW-1:0] best_x_o,
  input logic [OUT_YW-1:0] best_y_o,
  input logic [SUM_W-1:0]  best_sum_o,
  input logic              window_found_o
);

  // A stalled result transaction keeps its box position and sum.
  `ASSERT_ON(res_hold_a, clk_i, rst_ni, result_valid_o && !result_ready_i |=> result_valid_o && $stable(best_sum_o) && $stable(best_x_o) && $stable(best_y_o))

  // A frame without a fitting box reports all zeros.
  `ASSERT_ON(no_box_zero_a, clk_i, rst_ni, result_valid_o && !window_found_o |-> best_x_o == '0 && best_y_o == '0 && best_sum_o == '0)

  // A found box never ends in row 0 or column 0.
  `ASSERT_ON(box_origin_a, clk_i, rst_ni, result_valid_o && window_found_o |-> best_x_o != '0 && best_y_o != '0)

  // The memory sweep after reset keeps the pixel channel closed.
  `ASSERT_ALWAYS(clear_closed_a, clk_i, !rst_ni |=> !pixel_ready_o)

endmodule

bind max_box_sum_locator mbsl_checker u_mbsl_checker (.*);
